/* sv/longest_majority_letter_substring_top_defines.svh */
// Assertion macros shared by the longest majority letter substring RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef LONGEST_MAJORITY_LETTER_SUBSTRING_TOP_DEFINES_SVH
`define LONGEST_MAJORITY_LETTER_SUBSTRING_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lmls_pkg.sv */
// Package for the longest majority letter substring block.
// Holds sizes, the transfer structs and the sequencer state type; no dependencies.
package lmls_pkg;

	localparam int unsigned MAX_LEN      = 4096;
	localparam int unsigned LEN_W        = 13;
	localparam int unsigned TEXT_AW      = $clog2(MAX_LEN);
	localparam int unsigned TREE_DEPTH   = 2 * MAX_LEN + 2;
	localparam int unsigned TREE_AW      = $clog2(TREE_DEPTH);
	localparam int unsigned NODE_W       = TREE_AW + 1;
	localparam int unsigned BAL_W        = LEN_W + 1;
	localparam int unsigned LETTER_W     = 5;

	localparam logic [LEN_W-1:0]    INF_MARK    = '1;
	localparam logic [7:0]          LETTER_A    = 8'h61;
	localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0] longest_length;
		logic             overflowed;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_NEXT_K,
		ST_TXT_RD,
		ST_BAL,
		ST_Q_RD,
		ST_Q_CMP,
		ST_Q_END,
		ST_U_RD,
		ST_U_CMP,
		ST_FINISH
	} state_t;

endpackage

/* sv/longest_majority_letter_substring_top.sv */
// Top level of the longest majority letter substring block.
// Depends on lmls_pkg, lmls_ram and longest_majority_letter_substring_top_defines.svh.
//
// A string arrives one byte per transfer (start high while busy is low), one byte a
// cycle, and is written into the text memory. The transfer flagged by last_char starts
// the search; busy then stays high until the result appears on result for exactly one
// cycle, marked by done, and the receiver cannot stall it, so it must take the result
// in that cycle. The search makes one pass per letter 'a' to 'z'. Each pass first
// clears entries 1 to 2n+1 of the Fenwick minimum tree, for a string of n stored bytes,
// and then walks the string; every position costs a text read, a balance update, a tree
// query and a tree update, each tree walk reading one visited node at a time (at most 14
// nodes) because one RAM read port is shared by all tree accesses.
// Bytes beyond MAX_LEN are dropped and reported through the overflowed bit.
`include "longest_majority_letter_substring_top_defines.svh"

module longest_majority_letter_substring_top
	import lmls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	state_t state_q, state_d;

	logic [LEN_W-1:0]    len_q;
	logic                ovf_q;
	logic                done_q;
	result_t             result_q;
	logic [LETTER_W-1:0] letter_q;
	logic [LEN_W-1:0]    k_q;
	logic [BAL_W-1:0]    bal_q;
	logic [NODE_W-1:0]   node_q;
	logic [LEN_W-1:0]    earliest_q;
	logic [LEN_W-1:0]    best_q;
	logic [LEN_W-1:0]    put_pos_q;
	logic [TREE_AW-1:0]  clr_q;

	logic accept;

	// Text memory ports.
	logic                text_we;
	logic [7:0]          text_rd;

	// Tree memory ports.
	logic                tree_we;
	logic [TREE_AW-1:0]  tree_waddr;
	logic [LEN_W-1:0]    tree_wdata;
	logic [LEN_W-1:0]    tree_rd;

	logic [TREE_AW-1:0]  limit;
	logic [NODE_W-1:0]   node_low;
	logic                node_in_tree;
	logic                match;
	logic [BAL_W-1:0]    bal_next;
	logic [NODE_W-1:0]   query_idx;
	logic [NODE_W-1:0]   put_idx;
	logic [LEN_W-1:0]    span;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Highest tree index in use for the current string.
	assign limit        = TREE_AW'({len_q, 1'b1});
	assign node_low     = node_q & (-node_q);
	assign node_in_tree = (node_q != '0) && (node_q <= NODE_W'(limit));

	// One step of the running balance: +1 on the current letter, -1 otherwise.
	assign match    = (text_rd == (LETTER_A + 8'(letter_q)));
	assign bal_next = match ? (bal_q + BAL_W'(1)) : (bal_q - BAL_W'(1));

	// The query looks for balances strictly below the current one, which sit at
	// offset index n + balance; the update stores this position at n + 1 + balance.
	assign query_idx = NODE_W'(len_q) + {{(NODE_W-BAL_W){bal_next[BAL_W-1]}}, bal_next};
	assign put_idx   = NODE_W'(len_q) + {{(NODE_W-BAL_W){bal_q[BAL_W-1]}}, bal_q}
		+ NODE_W'(1);
	assign span      = k_q - earliest_q;

	assign text_we = accept && (len_q < LEN_W'(MAX_LEN));

	lmls_ram #(
		.DEPTH (MAX_LEN),
		.WIDTH (8)
	) u_text_ram (
		.clk   (clk),
		.we    (text_we),
		.waddr (len_q[TEXT_AW-1:0]),
		.wdata (item.char_byte),
		.raddr (k_q[TEXT_AW-1:0]),
		.rdata (text_rd)
	);

	lmls_ram #(
		.DEPTH (TREE_DEPTH),
		.WIDTH (LEN_W)
	) u_tree_ram (
		.clk   (clk),
		.we    (tree_we),
		.waddr (tree_waddr),
		.wdata (tree_wdata),
		.raddr (node_q[TREE_AW-1:0]),
		.rdata (tree_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and tree write control.
	always_comb begin
		state_d    = state_q;
		tree_we    = 1'b0;
		tree_waddr = clr_q;
		tree_wdata = INF_MARK;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.last_char) begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				tree_we = 1'b1;
				if (clr_q == limit) begin
					// Position zero with balance zero goes in next.
					state_d = ST_U_RD;
				end
			end
			ST_NEXT_K: begin
				if (k_q != len_q) begin
					state_d = ST_TXT_RD;
				end else if (letter_q == LAST_LETTER) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_CLEAR;
				end
			end
			ST_TXT_RD: state_d = ST_BAL;
			ST_BAL:    state_d = ST_Q_RD;
			ST_Q_RD: begin
				state_d = (node_q == '0) ? ST_Q_END : ST_Q_CMP;
			end
			ST_Q_CMP:  state_d = ST_Q_RD;
			ST_Q_END:  state_d = ST_U_RD;
			ST_U_RD: begin
				state_d = node_in_tree ? ST_U_CMP : ST_NEXT_K;
			end
			ST_U_CMP: begin
				// Positions arrive in increasing order, so only an empty node takes one.
				tree_waddr = node_q[TREE_AW-1:0];
				tree_wdata = put_pos_q;
				tree_we    = (put_pos_q < tree_rd);
				state_d    = ST_U_RD;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control registers that must come out of reset cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == ST_IDLE && accept) begin
				if (text_we) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_FINISH) begin
				done_q <= 1'b1;
				len_q  <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	// Search datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				letter_q <= '0;
				best_q   <= '0;
				clr_q    <= TREE_AW'(1);
			end
			ST_CLEAR: begin
				clr_q     <= clr_q + TREE_AW'(1);
				node_q    <= NODE_W'(len_q) + NODE_W'(1);
				put_pos_q <= '0;
				k_q       <= '0;
				bal_q     <= '0;
			end
			ST_NEXT_K: begin
				if (k_q == len_q) begin
					letter_q <= letter_q + LETTER_W'(1);
					clr_q    <= TREE_AW'(1);
				end
			end
			ST_TXT_RD: k_q <= k_q + LEN_W'(1);
			ST_BAL: begin
				bal_q      <= bal_next;
				node_q     <= query_idx;
				earliest_q <= INF_MARK;
			end
			ST_Q_CMP: begin
				if (tree_rd < earliest_q) begin
					earliest_q <= tree_rd;
				end
				node_q <= node_q - node_low;
			end
			ST_Q_END: begin
				if (earliest_q != INF_MARK && span > best_q) begin
					best_q <= span;
				end
				node_q    <= put_idx;
				put_pos_q <= k_q;
			end
			ST_U_CMP: node_q <= node_q + node_low;
			ST_FINISH: begin
				result_q.longest_length <= best_q;
				result_q.overflowed     <= ovf_q;
			end
			default: ;
		endcase
	end

	`LMLS_ASSERT_NOW(a_done_not_busy, done, !busy, "result strobe while still busy")
	`LMLS_ASSERT_NEXT(a_last_starts, accept && item.last_char, busy, "last byte did not start search")
	`LMLS_ASSERT_NOW(a_tree_in_range, tree_we, tree_waddr <= limit, "tree write beyond limit")
	`LMLS_ASSERT_NOW(a_best_bounded, busy, best_q <= len_q, "best length exceeds string length")

endmodule

/* sv/lmls_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies; depth and width come from the parameters.
module lmls_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 8,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* tb/tb_longest_majority_letter_substring_top.sv */
// Self-checking testbench for longest_majority_letter_substring_top.
// It needs lmls_pkg and the block itself. It drives directed and random strings and compares
// every result with a typed value or its own model of the longest majority-letter substring.
`timescale 1ns / 100ps

module tb_longest_majority_letter_substring_top;
	import lmls_pkg::*;

	// One directed row is one byte transfer. Rows marked TYPED carry the
	// result that the string they close must give. Rows marked PREDICT take
	// their expectation from the model.
	typedef struct packed {
		logic [7:0]       ch;
		logic             last;
		logic             typed;
		logic [LEN_W-1:0] len;
		logic             ovf;
	} directed_row_t;

	localparam logic TYPED   = 1'b1;
	localparam logic PREDICT = 1'b0;

	localparam int RANDOM_ITEMS   = 1750;
	localparam int OVERFLOW_BYTES = MAX_LEN + 4;
	localparam int DRAIN_CYCLES   = 50;

	// Strings of one byte: 'a', 'z', the edges of the byte range and the bytes just outside
	// 'a'..'z'; then short strings with a clear majority, and bytes that set every bit.
	localparam directed_row_t DIRECTED_ROWS [0:22] = '{
		'{"a",   1'b1, TYPED,   13'd1, 1'b0},
		'{"z",   1'b1, TYPED,   13'd1, 1'b0},
		'{8'h00, 1'b1, TYPED,   13'd0, 1'b0},
		'{8'hFF, 1'b1, TYPED,   13'd0, 1'b0},
		'{8'h60, 1'b1, TYPED,   13'd0, 1'b0},
		'{8'h7B, 1'b1, TYPED,   13'd0, 1'b0},
		'{"a",   1'b0, PREDICT, 13'd0, 1'b0},
		'{"a",   1'b0, PREDICT, 13'd0, 1'b0},
		'{"b",   1'b1, TYPED,   13'd3, 1'b0},
		'{"a",   1'b0, PREDICT, 13'd0, 1'b0},
		'{"b",   1'b1, TYPED,   13'd1, 1'b0},
		'{"z",   1'b0, PREDICT, 13'd0, 1'b0},
		'{"z",   1'b0, PREDICT, 13'd0, 1'b0},
		'{"~",   1'b0, PREDICT, 13'd0, 1'b0},
		'{"z",   1'b1, TYPED,   13'd4, 1'b0},
		'{8'h80, 1'b0, PREDICT, 13'd0, 1'b0},
		'{"q",   1'b0, PREDICT, 13'd0, 1'b0},
		'{"q",   1'b0, PREDICT, 13'd0, 1'b0},
		'{8'h41, 1'b1, PREDICT, 13'd0, 1'b0},
		'{8'h55, 1'b0, PREDICT, 13'd0, 1'b0},
		'{8'hAA, 1'b0, PREDICT, 13'd0, 1'b0},
		'{"m",   1'b0, PREDICT, 13'd0, 1'b0},
		'{"m",   1'b1, PREDICT, 13'd0, 1'b0}
	};

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	// Bytes of the string being collected, as the block keeps them, and whether
	// any byte past MAX_LEN was dropped from it.
	logic [7:0] text_bytes [$];
	logic       text_overflow = 1'b0;

	// Results still owed by the block, oldest first.
	result_t pending_results [$];

	// For the model: the first position at which each balance was reached,
	// indexed by balance + MAX_LEN.
	int first_reach [0:2*MAX_LEN];

	int sender_idle_pct = 0;
	int random_sent     = 0;
	int mismatch_count  = 0;

	longest_majority_letter_substring_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Longest stretch of text_bytes in which one letter is a strict majority.
	// With +1 for the letter and -1 for anything else, a stretch qualifies when
	// the balance at its end is above the balance at its start. The balance moves
	// in steps of one, so for a balance b at position k the earliest earlier
	// position with a smaller balance is position 0 when b is positive, and
	// otherwise the first time the balance fell to b - 1, if it ever did.
	function automatic result_t longest_majority();
		result_t    r;
		logic [7:0] letter;
		int         n;
		int         bal;
		int         low;
		int         best;
		int         earliest;

		n    = text_bytes.size();
		best = 0;
		for (int c = 0; c <= int'(LAST_LETTER); c++) begin
			letter   = LETTER_A + 8'(c);
			bal      = 0;
			low      = 0;
			first_reach[MAX_LEN] = 0;
			for (int k = 1; k <= n; k++) begin
				bal += (text_bytes[k-1] == letter) ? 1 : -1;
				if (bal > 0)
					earliest = 0;
				else if (bal - 1 >= low)
					earliest = first_reach[bal - 1 + MAX_LEN];
				else
					earliest = -1;
				if (earliest >= 0 && k - earliest > best)
					best = k - earliest;
				if (bal < low) begin
					low = bal;
					first_reach[bal + MAX_LEN] = k;
				end
			end
		end
		r.longest_length = best[LEN_W-1:0];
		r.overflowed     = text_overflow;
		return r;
	endfunction

	// Offers one byte, idling first at the current sender rate, and waits for
	// the transfer. The byte is then stored in the model; a closing byte queues
	// the result that the string owes, typed in or predicted.
	task automatic send_byte(input logic [7:0] ch, input logic last, input logic has_typed,
			input result_t typed_want);
		result_t predicted;

		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= '{char_byte: ch, last_char: last};
		// busy read right after the edge still holds its value from before it,
		// so the loop ends at the edge that took the transfer.
		do @(posedge clk); while (busy);

		if (text_bytes.size() < MAX_LEN)
			text_bytes.push_back(ch);
		else
			text_overflow = 1'b1;
		if (last) begin
			predicted = longest_majority();
			pending_results.push_back(has_typed ? typed_want : predicted);
			text_bytes.delete();
			text_overflow = 1'b0;
		end
	endtask

	// A random byte, most of the time from a small set of letters so that
	// majorities form, sometimes any letter and sometimes any byte.
	function automatic logic [7:0] pick_byte(input logic [7:0] pool [3]);
		int roll;

		roll = $urandom_range(99);
		if (roll < 60)
			return pool[$urandom_range(2)];
		else if (roll < 88)
			return LETTER_A + 8'($urandom_range(int'(LAST_LETTER)));
		else
			return 8'($urandom_range(255));
	endfunction

	// One random string of the given length, closed by its last byte.
	task automatic send_random_string(input int len);
		logic [7:0] pool [3];

		foreach (pool[i])
			pool[i] = LETTER_A + 8'($urandom_range(int'(LAST_LETTER)));
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(pool), i == len - 1, PREDICT, '0);
	endtask

	// Lowers start and holds off until the block has delivered every result
	// that is owed.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Each result is present for exactly one cycle with done high. done and
	// result come from registers, so after the edge they still show the cycle
	// that the edge closes.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with nothing expected: longest_length %0d overflowed %0b",
					$time, result.longest_length, result.overflowed);
			end else begin
				if (result.longest_length !== pending_results[0].longest_length) begin
					mismatch_count++;
					$display("%0t: longest_length expected %0d actual %0d", $time,
						pending_results[0].longest_length, result.longest_length);
				end
				if (result.overflowed !== pending_results[0].overflowed) begin
					mismatch_count++;
					$display("%0t: overflowed expected %0b actual %0b", $time,
						pending_results[0].overflowed, result.overflowed);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	initial begin
		int len_roll;
		int len;
		result_t typed_want;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the sender idling now and then.
		sender_idle_pct = 14;
		foreach (DIRECTED_ROWS[i]) begin
			typed_want.longest_length = DIRECTED_ROWS[i].len;
			typed_want.overflowed     = DIRECTED_ROWS[i].ovf;
			send_byte(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
				typed_want);
		end

		// Let every directed result come back before the long string, so the
		// sender sits idle for a whole search at least once.
		drain_results();

		// A string longer than the text memory: the bytes past MAX_LEN are
		// dropped, the search covers the first MAX_LEN, and overflowed is set.
		send_random_string(OVERFLOW_BYTES);

		// Random part in three phases: the sender idles little, then much,
		// then not at all. Most strings are short since the search time grows
		// with the length; a few are long.
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent < RANDOM_ITEMS / 3)
				sender_idle_pct = 14;
			else if (random_sent < 2 * RANDOM_ITEMS / 3)
				sender_idle_pct = 61;
			else
				sender_idle_pct = 0;
			len_roll = $urandom_range(99);
			if (len_roll < 85)
				len = $urandom_range(12, 1);
			else if (len_roll < 98)
				len = $urandom_range(48, 13);
			else
				len = $urandom_range(200, 49);
			send_random_string(len);
			random_sent += len;
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("[longest_majority_letter_substring_top] OK");
		else
			$display("[longest_majority_letter_substring_top] ERROR");
		$finish;
	end

	// This limit leaves a wide margin over the slowest correct run.
	initial begin
		#500_000_000;
		$display("[longest_majority_letter_substring_top] ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/lmls_pkg.sv
sv/lmls_ram.sv
sv/longest_majority_letter_substring_top.sv
tb/tb_longest_majority_letter_substring_top.sv
